// ===== hdl/rtdd_pkg.sv =====
package rtdd_pkg;

    // fixed field widths
    localparam int BASE_W  = 8;
    localparam int VALUE_W = 64;

    // product of one digit and one power of ten
    localparam int TERM_W  = VALUE_W + BASE_W;

    // power of ten times ten, with headroom for the carry
    localparam int PW10_W  = VALUE_W + 4;

    // smallest usable radix
    localparam logic [BASE_W-1:0] MIN_BASE = BASE_W'(2);

    // decimal radix applied to the running power
    localparam logic [3:0] DEC_RADIX = 4'd10;

endpackage

// ===== hdl/radix_to_decimal_digits_top.sv =====
// one item at a time: each base-b digit of the input takes a shift-subtract divider
// pass, a multiply and an accumulate; base 0/1 or number zero skip the digit work
// a new item is taken in the cycle after the result is handed to the output
// register, which waits while the previous result is still held
// reset: synchronous active-low i_rst_n clears the sequencer and the output valid
module radix_to_decimal_digits_top #(
    parameter int NUMBER_WIDTH = 31
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input item
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [NUMBER_WIDTH-1:0]       i_number,
    input  logic [rtdd_pkg::BASE_W-1:0]   i_base,
    // result item
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [rtdd_pkg::VALUE_W-1:0]  o_digits_value,
    output logic                          o_overflow,
    output logic                          o_bad_base
);
    import rtdd_pkg::*;

    // bit counter for one division pass
    localparam int CNT_W = $clog2(NUMBER_WIDTH);

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,  // waiting for an item
        S_DIV,   // one quotient bit per cycle
        S_MUL,   // digit times power of ten, next power
        S_ADD,   // accumulate with overflow checks
        S_FIN    // hand the result to the output register
    } t_state;

    t_state                r_state;
    logic [NUMBER_WIDTH-1:0] r_num;    // dividend shifting out, quotient shifting in
    logic [BASE_W-1:0]     r_rem;      // partial remainder, ends as the digit
    logic [BASE_W-1:0]     r_base;
    logic [CNT_W-1:0]      r_cnt;
    logic [VALUE_W-1:0]    r_acc;
    logic [VALUE_W-1:0]    r_pw;       // current power of ten
    logic                  r_pw_big;   // power of ten no longer fits 64 bits
    logic                  r_ovf;
    logic                  r_bad;
    logic [TERM_W-1:0]     r_term;
    logic [PW10_W-1:0]     r_pw10;
    logic                  r_o_valid;
    logic [VALUE_W-1:0]    r_o_value;
    logic                  r_o_ovf;
    logic                  r_o_bad;

    // shared shift-subtract divider step
    logic [BASE_W:0]       div_shift;
    logic                  div_ge;
    logic [BASE_W:0]       div_diff;
    logic [BASE_W-1:0]     n_rem;
    logic [NUMBER_WIDTH-1:0] n_num;

    assign div_shift = {r_rem, r_num[NUMBER_WIDTH-1]};
    assign div_ge    = (div_shift >= {1'b0, r_base});
    assign div_diff  = div_shift - {1'b0, r_base};
    // shifted remainder stays below twice the base, so the result fits
    assign n_rem     = div_ge ? div_diff[BASE_W-1:0] : div_shift[BASE_W-1:0];
    assign n_num     = {r_num[NUMBER_WIDTH-2:0], div_ge};

    // accumulate step
    logic [VALUE_W:0]      add_sum;
    logic                  term_big;

    assign add_sum  = {1'b0, r_acc} + {1'b0, r_term[VALUE_W-1:0]};
    assign term_big = (r_term[TERM_W-1:VALUE_W] != '0);

    logic in_fire;
    logic out_fire;
    logic out_free;

    assign in_fire  = i_valid && o_ready;
    assign out_fire = r_o_valid && i_ready;
    // output register can take a result this cycle
    assign out_free = !r_o_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
        end else begin
            // in S_FIN the load below decides the output valid
            if (out_fire && r_state != S_FIN) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_num    <= i_number;
                        r_base   <= i_base;
                        r_rem    <= '0;
                        r_cnt    <= '0;
                        r_acc    <= '0;
                        r_pw     <= VALUE_W'(1);
                        r_pw_big <= 1'b0;
                        r_ovf    <= 1'b0;
                        r_bad    <= (i_base < MIN_BASE);
                        // invalid base and zero both finish with no digit work
                        if (i_base < MIN_BASE || i_number == '0) begin
                            r_state <= S_FIN;
                        end else begin
                            r_state <= S_DIV;
                        end
                    end
                end
                S_DIV: begin
                    r_rem <= n_rem;
                    r_num <= n_num;
                    r_cnt <= r_cnt + CNT_W'(1);
                    if (r_cnt == CNT_W'(NUMBER_WIDTH - 1)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_term  <= TERM_W'(r_rem) * TERM_W'(r_pw);
                    r_pw10  <= PW10_W'(r_pw) * PW10_W'(DEC_RADIX);
                    r_state <= S_ADD;
                end
                S_ADD: begin
                    // a zero digit adds nothing, even past the 64-bit powers
                    if (r_rem != '0 && !r_ovf) begin
                        if (r_pw_big || term_big || add_sum[VALUE_W]) begin
                            r_ovf <= 1'b1;
                        end else begin
                            r_acc <= add_sum[VALUE_W-1:0];
                        end
                    end
                    if (!r_pw_big) begin
                        if (r_pw10[PW10_W-1:VALUE_W] != '0) begin
                            r_pw_big <= 1'b1;
                        end else begin
                            r_pw <= r_pw10[VALUE_W-1:0];
                        end
                    end
                    r_rem <= '0;
                    r_cnt <= '0;
                    if (r_num == '0) begin
                        r_state <= S_FIN;
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_FIN: begin
                    // wait here while the previous result is still held
                    if (out_free) begin
                        r_o_valid <= 1'b1;
                        r_o_value <= r_ovf ? '1 : r_acc;
                        r_o_ovf   <= r_ovf;
                        r_o_bad   <= r_bad;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_ready        = (r_state == S_IDLE);
    assign o_valid        = r_o_valid;
    assign o_digits_value = r_o_value;
    assign o_overflow     = r_o_ovf;
    assign o_bad_base     = r_o_bad;

    // the partial remainder never reaches the base during a division pass
    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_base))
        else $error("partial remainder not below base");

    // an invalid base gives zero and no overflow
    a_bad_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_bad_base) |-> (o_digits_value == '0 && !o_overflow))
        else $error("invalid base result not zero");

    // overflow always saturates
    a_ovf_saturates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_overflow) |-> (&o_digits_value))
        else $error("overflow without saturation");

    // a result moves to the output only when the slot is free
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN && r_o_valid && !i_ready) |=> (r_state == S_FIN))
        else $error("held result overwritten");

endmodule

// ===== tb/sv/tb.sv =====
module tb;

    import rtdd_pkg::*;

    // number width under test, matches the block default
    localparam int NW = 31;

    // hard stop on cycles, several times the slowest legal run
    localparam int CYCLE_LIMIT = 6_000_000;

    // long receiver hold-off, enough for the block to back up and stall its input
    localparam int HOLD_CYCLES = 400;

    // result sizes
    localparam logic [VALUE_W-1:0] ALL_ONES = {VALUE_W{1'b1}};
    localparam logic [NW-1:0]      NUM_MAX  = {NW{1'b1}};

    // one predicted result
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               ovf;
        logic               bad;
    } t_digits_result;

    // prediction tagged with the item that caused it, for messages
    typedef struct packed {
        logic [NW-1:0]     number;
        logic [BASE_W-1:0] base;
        t_digits_result    res;
    } t_digits_expect;

    // dut ports, every input starts at a known value
    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                i_valid  = 1'b0;
    logic                o_ready;
    logic [NW-1:0]       i_number = '0;
    logic [BASE_W-1:0]   i_base   = '0;
    logic                o_valid;
    logic                i_ready  = 1'b0;
    logic [VALUE_W-1:0]  o_digits_value;
    logic                o_overflow;
    logic                o_bad_base;

    // idling switches, flipped by the main sequence per phase
    bit tx_idle_en = 1'b1;
    bit rx_idle_en = 1'b1;
    int results_seen = 0;

    radix_to_decimal_digits_top #(
        .NUMBER_WIDTH(NW)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_number       (i_number),
        .i_base         (i_base),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_digits_value (o_digits_value),
        .o_overflow     (o_overflow),
        .o_bad_base     (o_bad_base)
    );

    // keeps the predicted results in order and checks each arriving one
    class digit_scoreboard;
        t_digits_expect expected_q[$];
        int             mismatches = 0;

        // base-b digits of the number, least significant first, summed as
        // digit times ten to its position, saturating past 64 bits
        function t_digits_result spell_in_decimal(logic [NW-1:0] num, logic [BASE_W-1:0] b);
            t_digits_result     r;
            logic [VALUE_W-1:0] n;
            logic [VALUE_W-1:0] rdx;
            logic [VALUE_W-1:0] d;
            logic [VALUE_W-1:0] pw;
            logic [VALUE_W-1:0] term;
            logic [VALUE_W-1:0] acc;
            bit                 pw_big;
            bit                 ovf;
            r = '0;
            if (b < MIN_BASE) begin
                r.bad = 1'b1;
                return r;
            end
            n      = VALUE_W'(num);
            rdx    = VALUE_W'(b);
            acc    = '0;
            pw     = VALUE_W'(1);
            pw_big = 1'b0;
            ovf    = 1'b0;
            while (n != '0) begin
                d = n % rdx;
                n = n / rdx;
                // zero digits never overflow, even past the 64-bit powers
                if (d != '0 && !ovf) begin
                    if (pw_big || pw > ALL_ONES / d) begin
                        ovf = 1'b1;
                    end else begin
                        term = d * pw;
                        if (acc > ALL_ONES - term) ovf = 1'b1;
                        else acc = acc + term;
                    end
                end
                if (!pw_big) begin
                    if (pw > ALL_ONES / VALUE_W'(DEC_RADIX)) pw_big = 1'b1;
                    else pw = pw * VALUE_W'(DEC_RADIX);
                end
            end
            r.value = ovf ? ALL_ONES : acc;
            r.ovf   = ovf;
            return r;
        endfunction

        function void note_input(logic [NW-1:0] num, logic [BASE_W-1:0] b);
            t_digits_expect e;
            e.number = num;
            e.base   = b;
            e.res    = spell_in_decimal(num, b);
            expected_q.push_back(e);
        endfunction

        function void flag_field(string field, t_digits_expect e,
                                 logic [VALUE_W-1:0] exp_v, logic [VALUE_W-1:0] act_v);
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: number %0d base %0d expected %0h got %0h",
                         field, e.number, e.base, exp_v, act_v);
        endfunction

        function void check_result(logic [VALUE_W-1:0] value, logic ovf, logic bad);
            t_digits_expect e;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: value %0h overflow %0b bad_base %0b",
                             value, ovf, bad);
                return;
            end
            e = expected_q.pop_front();
            if (value !== e.res.value) flag_field("digits_value", e, e.res.value, value);
            if (ovf !== e.res.ovf)     flag_field("overflow", e, VALUE_W'(e.res.ovf),
                                                  VALUE_W'(ovf));
            if (bad !== e.res.bad)     flag_field("bad_base", e, VALUE_W'(e.res.bad),
                                                  VALUE_W'(bad));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    digit_scoreboard board = new();

    // free running clock, period 10
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // cycle counter watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // offer one item, hold it until taken, then maybe idle a random burst
    task automatic send_item(input logic [NW-1:0] num, input logic [BASE_W-1:0] b);
        int gap;
        i_valid  <= 1'b1;
        i_number <= num;
        i_base   <= b;
        // o_ready read here is the value from before the edge
        do @(posedge i_clk); while (!o_ready);
        board.note_input(num, b);
        gap = 0;
        if (tx_idle_en && $urandom_range(0, 5) == 0) gap = $urandom_range(1, 19);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // sender goes quiet until every predicted result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
    endtask

    // random base, weighted toward the slow radix 2, the invalid ones and the edges
    function automatic logic [BASE_W-1:0] pick_base();
        int sel;
        sel = $urandom_range(0, 19);
        unique case (sel)
            0: begin
                return BASE_W'($urandom_range(0, 1));
            end
            1, 2, 3: begin
                return MIN_BASE;
            end
            4: begin
                return BASE_W'(10);
            end
            5: begin
                return BASE_W'($urandom_range(254, 255));
            end
            default: begin
                return BASE_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // random number of random width so short and long digit strings both show up
    function automatic logic [NW-1:0] pick_number();
        int                 sel;
        int                 w;
        logic [VALUE_W-1:0] mask;
        sel = $urandom_range(0, 15);
        if (sel == 0) return '0;
        if (sel == 1) return NUM_MAX;
        w    = $urandom_range(1, NW);
        mask = (VALUE_W'(1) << w) - VALUE_W'(1);
        return NW'({$urandom, $urandom} & mask);
    endfunction

    task automatic send_random(input int count);
        for (int k = 0; k < count; k++) send_item(pick_number(), pick_base());
    endtask

    // result side: check, then choose ready for the next cycle
    initial begin : result_sink
        int hold_left;
        int stall_left;
        hold_left  = 0;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_valid && i_ready) begin
                board.check_result(o_digits_value, o_overflow, o_bad_base);
                results_seen++;
                // long hold-off while the sender keeps offering
                if (results_seen == 150 || results_seen == 600) hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                i_ready <= 1'b0;
            end else if (rx_idle_en && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 19) - 1;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
            end
        end
    end

    // main sequence
    initial begin
        // reset asserted once, at the start
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: invalid bases
        send_item('0, BASE_W'(0));
        send_item(NUM_MAX, BASE_W'(0));
        send_item(NW'(12345), BASE_W'(1));
        send_item(NUM_MAX, BASE_W'(1));
        // zero number
        send_item('0, MIN_BASE);
        send_item('0, BASE_W'(255));
        // base ten gives the number back
        send_item(NUM_MAX, BASE_W'(10));
        send_item(NW'(123456789), BASE_W'(10));
        // binary: twenty ones still fit, one more digit saturates
        send_item(NW'(1), MIN_BASE);
        send_item(NW'(20'hFFFFF), MIN_BASE);
        send_item(NW'(1 << 20), MIN_BASE);
        send_item(NW'(1 << 30), MIN_BASE);
        send_item(NUM_MAX, MIN_BASE);
        // base three: twenty digits with the top one at ten to the nineteenth
        send_item(NW'(1162261467), BASE_W'(3));
        send_item(NUM_MAX, BASE_W'(3));
        // digits above nine overlap their neighbors
        send_item(NW'(255), BASE_W'(255));
        send_item(NW'(254), BASE_W'(255));
        send_item(NUM_MAX, BASE_W'(255));
        send_item(NW'(8'hAB), BASE_W'(16));
        send_item(NW'(65535), BASE_W'(16));
        send_item(NUM_MAX, BASE_W'(16));
        send_item(NW'(1000), BASE_W'(11));
        send_item(NUM_MAX, BASE_W'(128));
        send_item(NW'(7), BASE_W'(8));
        drain_results();

        // random with idling on both sides, long hold-off lands in here
        send_random(400);
        // sender pauses until everything is back
        drain_results();

        // sender streams, receiver still idles
        tx_idle_en = 1'b0;
        send_random(300);
        drain_results();

        // last part: no idling anywhere
        rx_idle_en = 1'b0;
        send_random(400);
        drain_results();

        // wait on to catch any stray result
        repeat (40) @(posedge i_clk);

        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rtdd_pkg.sv
hdl/radix_to_decimal_digits_top.sv
tb/sv/tb.sv
